// ----- rtl/idea_pkg.sv -----
`default_nettype none
package idea_pkg;

  localparam int WORD_W  = 16;
  localparam int BLOCK_W = 64;
  localparam int KEY_W   = 128;
  localparam int CFG_W   = 64;
  localparam int CFG_IDX_W = 2;

  // Modulus of the IDEA multiplication group.
  localparam logic [17:0] MOD_P = 18'h10001;

  // Key schedule rotation after each group of eight words.
  localparam int KEY_ROT = 25;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_HIGH = 2'd0,
    REG_KEY_LOW  = 2'd1,
    REG_DECRYPT  = 2'd2,
    REG_NONE     = 2'd3
  } cfg_reg_t;

endpackage
`default_nettype wire

// ----- rtl/idea_ram.sv -----
`default_nettype none
module idea_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 52
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/idea_mulmod.sv -----
`default_nettype none
module idea_mulmod
  import idea_pkg::*;
(
  input  wire logic [WORD_W-1:0] a,
  input  wire logic [WORD_W-1:0] b,
  output logic      [WORD_W-1:0] prod
);

  // A zero operand stands for 65536.
  logic [16:0] xa;
  logic [16:0] xb;
  logic [33:0] p;
  logic [17:0] lo;
  logic [17:0] hi;
  logic [17:0] r;

  always_comb begin
    xa = (a == '0) ? 17'h10000 : {1'b0, a};
    xb = (b == '0) ? 17'h10000 : {1'b0, b};
    p  = 34'(xa) * 34'(xb);
    lo = {2'b00, p[15:0]};
    hi = p[33:16];
    r  = (lo >= hi) ? 18'(lo - hi) : 18'(lo + MOD_P - hi);
    prod = r[15:0];
  end

endmodule
`default_nettype wire

// ----- rtl/idea_block_cipher.sv -----
//  Channel   Direction  Handshake             Payload
//  in_       request    in_valid / in_stall   in_block_in  (64 bits)
//  out_      result     out_valid / out_stall out_block_out (64 bits)
//  cfg_      write      cfg_we                cfg_index, cfg_wdata
//
//  A block runs on the one mod-65537 multiplier from acceptance to result: a subkey fetch,
//  seven steps per round, four for the output transform. After reset or a key or mode
//  write the subkeys are rebuilt first: a start state, then each encryption word in turn,
//  or to decrypt the plain words in turn and each inverse by squaring and multiplying
//  (4*ROUNDS+2 plain words, 2*ROUNDS+2 inverses). Reset is synchronous, active low.
//  A stalled result stays in the output register and holds the core until taken.
`default_nettype none
module idea_block_cipher
  import idea_pkg::*;
#(
  parameter int ROUNDS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [BLOCK_W-1:0]   in_block_in,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [BLOCK_W-1:0]   out_block_out,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int NKEYS = 6 * ROUNDS + 4;
  localparam int KA_W  = $clog2(NKEYS);
  localparam int RND_W = $clog2(ROUNDS + 1);
  localparam logic [KA_W-1:0]  LAST_KEY = KA_W'(NKEYS - 1);
  localparam logic [KA_W-1:0]  DEC_BASE = KA_W'(6 * ROUNDS);
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS);

  typedef enum logic [2:0] {
    S_IDLE, S_EXP, S_INV, S_WAIT, S_RUN, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic [KEY_W-1:0]   key_r, key_nxt;       // configured key
  logic               dec_r, dec_nxt;
  logic               ready_r, ready_nxt;   // subkeys match key and mode
  logic [KEY_W-1:0]   sched_r, sched_nxt;   // rotating schedule copy
  logic [KA_W-1:0]    widx_r, widx_nxt;     // encryption word index
  logic [2:0]         slot_r, slot_nxt;     // place of word in its group
  logic [RND_W-1:0]   grp_r, grp_nxt;
  logic [KA_W-1:0]    dbase_r, dbase_nxt;
  logic [KA_W-1:0]    dst_r, dst_nxt;
  logic [WORD_W-1:0]  acc_r, acc_nxt;
  logic [WORD_W-1:0]  base_r, base_nxt;
  logic [4:0]         icnt_r, icnt_nxt;
  logic [KA_W-1:0]    ka_r, ka_nxt;
  logic [2:0]         step_r, step_nxt;
  logic [RND_W-1:0]   rnd_r, rnd_nxt;
  logic [WORD_W-1:0]  x1_r, x1_nxt, x2_r, x2_nxt, x3_r, x3_nxt, x4_r, x4_nxt;
  logic [WORD_W-1:0]  s_r, s_nxt, t_r, t_nxt;
  logic               ov_r, ov_nxt;
  logic [BLOCK_W-1:0] ob_r, ob_nxt;

  logic [WORD_W-1:0]  mul_a, mul_b, mul_p;
  logic               ram_we;
  logic [KA_W-1:0]    ram_wa;
  logic [WORD_W-1:0]  ram_wd, ram_rd;

  logic [WORD_W-1:0]  word;
  logic               edge_grp;
  logic [KA_W-1:0]    dec_dst;
  logic               advance;
  logic               cfg_hit;
  logic               final_ph;
  logic [WORD_W-1:0]  s2;

  idea_mulmod u_mul (
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_p)
  );

  idea_ram #(.WIDTH(WORD_W), .DEPTH(NKEYS)) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .raddr (ka_r),
    .rdata (ram_rd)
  );

  assign in_stall      = !((state_r == S_IDLE) && ready_r);
  assign out_valid     = ov_r;
  assign out_block_out = ob_r;

  always_comb begin
    word     = sched_r[KEY_W-1 -: WORD_W];
    // The first group and the last group keep the two additive keys in order.
    edge_grp = (grp_r == '0) || (grp_r == RND_LAST);
    case (slot_r)
      3'd0:    dec_dst = dbase_r + KA_W'(4);
      3'd1:    dec_dst = dbase_r + KA_W'(5);
      3'd2:    dec_dst = dbase_r;
      3'd3:    dec_dst = dbase_r + (edge_grp ? KA_W'(1) : KA_W'(2));
      3'd4:    dec_dst = dbase_r + (edge_grp ? KA_W'(2) : KA_W'(1));
      default: dec_dst = dbase_r + KA_W'(3);
    endcase
    cfg_hit  = cfg_we && (cfg_index != REG_NONE);
    final_ph = (rnd_r == RND_LAST);
    s2       = 16'(s_r + t_r);
  end

  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    dec_nxt   = dec_r;
    ready_nxt = ready_r;
    sched_nxt = sched_r;
    widx_nxt  = widx_r;
    slot_nxt  = slot_r;
    grp_nxt   = grp_r;
    dbase_nxt = dbase_r;
    dst_nxt   = dst_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    icnt_nxt  = icnt_r;
    ka_nxt    = ka_r;
    step_nxt  = step_r;
    rnd_nxt   = rnd_r;
    x1_nxt = x1_r; x2_nxt = x2_r; x3_nxt = x3_r; x4_nxt = x4_r;
    s_nxt  = s_r;  t_nxt  = t_r;
    ov_nxt = ov_r && out_stall;
    ob_nxt = ob_r;
    mul_a  = acc_r;
    mul_b  = base_r;
    ram_we = 1'b0;
    ram_wa = widx_r;
    ram_wd = word;
    advance = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (!ready_r) begin
          sched_nxt = key_r;
          widx_nxt  = '0;
          slot_nxt  = 3'd2;
          grp_nxt   = '0;
          dbase_nxt = DEC_BASE;
          state_nxt = S_EXP;
        end else if (in_valid) begin
          x1_nxt = in_block_in[63:48];
          x2_nxt = in_block_in[47:32];
          x3_nxt = in_block_in[31:16];
          x4_nxt = in_block_in[15:0];
          ka_nxt    = '0;
          step_nxt  = '0;
          rnd_nxt   = '0;
          state_nxt = S_WAIT;
        end
      end

      S_EXP: begin
        if (!dec_r) begin
          ram_we  = 1'b1;
          advance = 1'b1;
        end else if ((slot_r == 3'd2) || (slot_r == 3'd5)) begin
          dst_nxt   = dec_dst;
          acc_nxt   = 16'd1;
          base_nxt  = word;
          icnt_nxt  = '0;
          state_nxt = S_INV;
        end else begin
          ram_we  = 1'b1;
          ram_wa  = dec_dst;
          ram_wd  = (slot_r >= 3'd3) ? 16'((~word) + 16'd1) : word;
          advance = 1'b1;
        end
      end

      S_INV: begin
        // Inverse as a^65535: multiply and square alternately.
        icnt_nxt = 5'(icnt_r + 5'd1);
        if (icnt_r[0] == 1'b0) begin
          acc_nxt = mul_p;
        end else begin
          mul_a    = base_r;
          base_nxt = mul_p;
        end
        if (icnt_r == 5'd31) begin
          ram_we    = 1'b1;
          ram_wa    = dst_r;
          ram_wd    = acc_r;
          advance   = 1'b1;
          state_nxt = S_EXP;
        end
      end

      S_WAIT: begin
        ka_nxt    = KA_W'(ka_r + 1'b1);
        state_nxt = S_RUN;
      end

      S_RUN: begin
        mul_b = ram_rd;
        if (final_ph ? (step_r < 3'd3) : (step_r != 3'd5)) begin
          ka_nxt = KA_W'(ka_r + 1'b1);
        end
        step_nxt = 3'(step_r + 3'd1);
        case (step_r)
          3'd0: begin
            mul_a  = x1_r;
            x1_nxt = mul_p;
          end
          3'd1: begin
            if (final_ph) x3_nxt = 16'(x3_r + ram_rd);
            else          x2_nxt = 16'(x2_r + ram_rd);
          end
          3'd2: begin
            if (final_ph) x2_nxt = 16'(x2_r + ram_rd);
            else          x3_nxt = 16'(x3_r + ram_rd);
          end
          3'd3: begin
            mul_a  = x4_r;
            x4_nxt = mul_p;
            if (final_ph) begin
              state_nxt = S_OUT;
            end
          end
          3'd4: begin
            mul_a = x1_r ^ x3_r;
            s_nxt = mul_p;
          end
          3'd5: begin
            mul_a = 16'((x2_r ^ x4_r) + s_r);
            t_nxt = mul_p;
          end
          default: begin
            // Mixing and the swap of the two middle words.
            s_nxt    = s2;
            x1_nxt   = x1_r ^ t_r;
            x4_nxt   = x4_r ^ s2;
            x2_nxt   = x3_r ^ t_r;
            x3_nxt   = x2_r ^ s2;
            step_nxt = '0;
            rnd_nxt  = RND_W'(rnd_r + 1'b1);
          end
        endcase
      end

      S_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          ob_nxt    = {x1_r, x3_r, x2_r, x4_r};
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (advance) begin
      widx_nxt = KA_W'(widx_r + 1'b1);
      if (widx_r[2:0] == 3'd7) begin
        sched_nxt = {sched_r[KEY_W-1-WORD_W-KEY_ROT:0],
                     sched_r[KEY_W-1 -: WORD_W+KEY_ROT]};
      end else begin
        sched_nxt = {sched_r[KEY_W-1-WORD_W:0], sched_r[KEY_W-1 -: WORD_W]};
      end
      if (slot_r == 3'd5) begin
        slot_nxt  = '0;
        grp_nxt   = RND_W'(grp_r + 1'b1);
        dbase_nxt = KA_W'(dbase_r - KA_W'(6));
      end else begin
        slot_nxt = 3'(slot_r + 3'd1);
      end
      if (widx_r == LAST_KEY) begin
        ready_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
    end

    // A key or mode write restarts the schedule from the new settings, including
    // one that would otherwise start from the old key in this very cycle.
    if (cfg_we) begin
      case (cfg_index)
        REG_KEY_HIGH: key_nxt[127:64] = cfg_wdata;
        REG_KEY_LOW:  key_nxt[63:0]   = cfg_wdata;
        REG_DECRYPT:  dec_nxt         = cfg_wdata[0];
        default:      ;
      endcase
    end
    if (cfg_hit) begin
      ready_nxt = 1'b0;
      if ((state_r == S_EXP) || (state_r == S_INV) ||
          ((state_r == S_IDLE) && !ready_r)) begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      key_r   <= '0;
      dec_r   <= 1'b0;
      ready_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      key_r   <= key_nxt;
      dec_r   <= dec_nxt;
      ready_r <= ready_nxt;
      ov_r    <= ov_nxt;
    end
    sched_r <= sched_nxt;
    widx_r  <= widx_nxt;
    slot_r  <= slot_nxt;
    grp_r   <= grp_nxt;
    dbase_r <= dbase_nxt;
    dst_r   <= dst_nxt;
    acc_r   <= acc_nxt;
    base_r  <= base_nxt;
    icnt_r  <= icnt_nxt;
    ka_r    <= ka_nxt;
    step_r  <= step_nxt;
    rnd_r   <= rnd_nxt;
    x1_r <= x1_nxt; x2_r <= x2_nxt; x3_r <= x3_nxt; x4_r <= x4_nxt;
    s_r  <= s_nxt;  t_r  <= t_nxt;
    ob_r <= ob_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/idea_checker.sv -----
`default_nettype none
module idea_checker
  import idea_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [BLOCK_W-1:0]   out_block_out,
  input wire logic                 cfg_we,
  input wire logic [CFG_IDX_W-1:0] cfg_index
);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A stalled result is held.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_block_out))
    else $error("stalled result changed");

  // One request at a time: the core is busy after taking one.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

  // A key or mode write forces a schedule rebuild before the next request.
  a_rekey: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index != REG_NONE) |=> in_stall)
    else $error("request taken with stale subkeys");

endmodule

bind idea_block_cipher idea_checker u_idea_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_block_out (out_block_out),
  .cfg_we        (cfg_we),
  .cfg_index     (cfg_index)
);
`default_nettype wire

// ----- verif/testbench.sv -----
`default_nettype none
module testbench;
  import idea_pkg::*;

  // Longest quiet spell the core can need: a decryption key rebuild (eighteen
  // inverses) followed by one full block.
  localparam int SETTLE = 800;
  localparam int NUM_PHASES = 10;
  localparam int PER_PHASE = 50;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [BLOCK_W-1:0] in_block_in;
  logic               out_valid;
  logic               out_stall;
  logic [BLOCK_W-1:0] out_block_out;
  logic               cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]   cfg_wdata;

  idea_block_cipher dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_block_in(in_block_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_block_out(out_block_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor state: our own copy of the key registers and of the subkeys.
  // ---------------------------------------------------------------------
  logic [127:0] cipher_key;
  logic         decrypting;
  logic         schedule_valid;
  logic [15:0]  subkeys [0:51];

  // Expected output blocks, oldest first.
  logic [63:0]  pending_blocks [$];

  int  fail_count;
  int  requests_sent;
  int  blocks_checked;
  int  key_writes;
  bit  idling_enabled;
  bit  hold_off_go;

  // Multiplication modulo 65537 with the all-zero word standing for 65536.
  function automatic logic [15:0] idea_mul(input logic [15:0] a, input logic [15:0] b);
    longint unsigned x, y, p, lo, hi, r;
    x = (a == 16'd0) ? 64'd65536 : 64'(a);
    y = (b == 16'd0) ? 64'd65536 : 64'(b);
    p = x * y;
    lo = p & 64'hFFFF;
    hi = p >> 16;
    r = (lo >= hi) ? lo - hi : lo + 64'd65537 - hi;
    return r[15:0];
  endfunction

  // Inverse by raising to the power 65535, one squaring per exponent bit.
  function automatic logic [15:0] idea_mul_inv(input logic [15:0] a);
    logic [15:0] acc, base;
    acc = 16'd1;
    base = a;
    for (int i = 0; i < 16; i++) begin
      acc = idea_mul(acc, base);
      base = idea_mul(base, base);
    end
    return acc;
  endfunction

  function automatic logic [15:0] idea_neg(input logic [15:0] a);
    return 16'(17'h10000 - 17'(a));
  endfunction

  // Rebuilds the 52 subkeys for the current key and direction.
  function automatic void build_schedule();
    logic [15:0]  enc [0:51];
    logic [127:0] k;
    int d, e;
    k = cipher_key;
    for (int i = 0; i < 52; i++) begin
      enc[i] = k[127 - 16 * (i % 8) -: 16];
      if (i % 8 == 7) k = {k[102:0], k[127:103]};
    end
    if (!decrypting) begin
      for (int i = 0; i < 52; i++) subkeys[i] = enc[i];
      return;
    end
    // Decryption walks the encryption keys backwards, round by round, with
    // the middle additive keys swapped except in the first and the last group.
    d = 48;
    subkeys[d]     = idea_mul_inv(enc[0]);
    subkeys[d + 1] = idea_neg(enc[1]);
    subkeys[d + 2] = idea_neg(enc[2]);
    subkeys[d + 3] = idea_mul_inv(enc[3]);
    e = 4;
    for (int r = 1; r <= 8; r++) begin
      d -= 6;
      subkeys[d + 4] = enc[e];
      subkeys[d + 5] = enc[e + 1];
      e += 2;
      subkeys[d] = idea_mul_inv(enc[e]);
      if (r < 8) begin
        subkeys[d + 1] = idea_neg(enc[e + 2]);
        subkeys[d + 2] = idea_neg(enc[e + 1]);
      end else begin
        subkeys[d + 1] = idea_neg(enc[e + 1]);
        subkeys[d + 2] = idea_neg(enc[e + 2]);
      end
      subkeys[d + 3] = idea_mul_inv(enc[e + 3]);
      e += 4;
    end
  endfunction

  // Runs one block through eight rounds and the output transform.
  function automatic logic [63:0] idea_transform(input logic [63:0] blk);
    logic [15:0] x1, x2, x3, x4, s, t, swap;
    int k;
    if (!schedule_valid) begin
      build_schedule();
      schedule_valid = 1'b1;
    end
    {x1, x2, x3, x4} = blk;
    k = 0;
    for (int r = 0; r < 8; r++) begin
      x1 = idea_mul(x1, subkeys[k]);
      x2 = x2 + subkeys[k + 1];
      x3 = x3 + subkeys[k + 2];
      x4 = idea_mul(x4, subkeys[k + 3]);
      s = idea_mul(x1 ^ x3, subkeys[k + 4]);
      t = idea_mul((x2 ^ x4) + s, subkeys[k + 5]);
      s = s + t;
      k += 6;
      x1 ^= t;
      x4 ^= s;
      swap = x2 ^ s;
      x2 = x3 ^ t;
      x3 = swap;
    end
    return {idea_mul(x1, subkeys[k]), 16'(x3 + subkeys[k + 1]),
            16'(x2 + subkeys[k + 2]), idea_mul(x4, subkeys[k + 3])};
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------

  // Lowers the request and waits until every expected block has come back,
  // then lets the core finish any key rebuild it may still be running.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
    drain_results();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    key_writes++;
    // An unused index changes nothing and leaves the schedule as it was.
    case (idx)
      REG_KEY_HIGH: begin
        cipher_key[127:64] = value;
        schedule_valid = 1'b0;
      end
      REG_KEY_LOW: begin
        cipher_key[63:0] = value;
        schedule_valid = 1'b0;
      end
      REG_DECRYPT: begin
        decrypting = value[0];
        schedule_valid = 1'b0;
      end
      default: ;
    endcase
  endtask

  // Offers one request and waits for it to be taken. Valid stays high on
  // return so that back-to-back requests leave no gap unless one is drawn.
  task automatic send_block(input logic [63:0] blk, input bit typed, input logic [63:0] typed_out);
    logic [63:0] predicted;
    @(negedge clk);
    while (idling_enabled && $urandom_range(99) < 21) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_block_in = blk;
    do @(posedge clk); while (in_stall);
    predicted = idea_transform(blk);
    pending_blocks.push_back(typed ? typed_out : predicted);
    requests_sent++;
  endtask

  function automatic logic [63:0] random_word();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    case ($urandom_range(7))
      0: w = 64'd0;
      1: w = '1;
      default: ;
    endcase
    return w;
  endfunction

  // ---------------------------------------------------------------------
  // Directed table: register writes and blocks in order. Expected results
  // are typed in only for the published vector and its round trip.
  // ---------------------------------------------------------------------
  typedef struct packed {
    logic        is_write;
    cfg_reg_t    reg_idx;
    logic [63:0] data;
    logic        typed;
    logic [63:0] result;
  } step_t;

  localparam logic [63:0] VEC_PLAIN  = 64'h0000_0001_0002_0003;
  localparam logic [63:0] VEC_CIPHER = 64'h11FB_ED2B_0198_6DE5;

  step_t directed [0:26];

  initial begin
    directed = '{
      '{1'b1, REG_KEY_HIGH, 64'h0001_0002_0003_0004, 1'b0, 64'd0},
      '{1'b1, REG_KEY_LOW,  64'h0005_0006_0007_0008, 1'b0, 64'd0},
      '{1'b1, REG_DECRYPT,  64'd0,                   1'b0, 64'd0},
      '{1'b0, REG_NONE,     VEC_PLAIN,               1'b1, VEC_CIPHER},
      '{1'b0, REG_NONE,     64'd0,                   1'b0, 64'd0},
      '{1'b0, REG_NONE,     '1,                      1'b0, 64'd0},
      '{1'b0, REG_NONE,     64'h0000_FFFF_0000_FFFF, 1'b0, 64'd0},
      '{1'b1, REG_DECRYPT,  64'd1,                   1'b0, 64'd0},
      '{1'b0, REG_NONE,     VEC_CIPHER,              1'b1, VEC_PLAIN},
      '{1'b0, REG_NONE,     64'd0,                   1'b0, 64'd0},
      '{1'b0, REG_NONE,     '1,                      1'b0, 64'd0},
      // A write to the unused index must leave the decryption keys alone.
      '{1'b1, REG_NONE,     '1,                      1'b0, 64'd0},
      '{1'b0, REG_NONE,     VEC_CIPHER,              1'b1, VEC_PLAIN},
      // Only bit 0 of the mode value counts, so 2 selects encryption.
      '{1'b1, REG_DECRYPT,  64'd2,                   1'b0, 64'd0},
      '{1'b0, REG_NONE,     VEC_PLAIN,               1'b1, VEC_CIPHER},
      // All-zero key: every product uses the word that stands for 65536.
      '{1'b1, REG_KEY_HIGH, 64'd0,                   1'b0, 64'd0},
      '{1'b1, REG_KEY_LOW,  64'd0,                   1'b0, 64'd0},
      '{1'b0, REG_NONE,     64'd0,                   1'b0, 64'd0},
      '{1'b0, REG_NONE,     '1,                      1'b0, 64'd0},
      '{1'b1, REG_KEY_HIGH, '1,                      1'b0, 64'd0},
      '{1'b1, REG_KEY_LOW,  '1,                      1'b0, 64'd0},
      '{1'b0, REG_NONE,     64'd0,                   1'b0, 64'd0},
      '{1'b0, REG_NONE,     '1,                      1'b0, 64'd0},
      '{1'b1, REG_DECRYPT,  '1,                      1'b0, 64'd0},
      '{1'b0, REG_NONE,     64'd0,                   1'b0, 64'd0},
      '{1'b0, REG_NONE,     '1,                      1'b0, 64'd0},
      '{1'b0, REG_NONE,     64'h8000_0000_0000_0001, 1'b0, 64'd0}
    };
  end

  // ---------------------------------------------------------------------
  // Sender: reset, the directed table, then random phases under fresh keys.
  // ---------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_block_in = '0;
    cfg_we = 1'b0;
    cfg_index = REG_NONE;
    cfg_wdata = '0;
    cipher_key = '0;
    decrypting = 1'b0;
    schedule_valid = 1'b0;
    fail_count = 0;
    requests_sent = 0;
    blocks_checked = 0;
    key_writes = 0;
    idling_enabled = 1'b1;
    hold_off_go = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Blocks straight after reset use the all-zero reset key.
    send_block(64'h0123_4567_89AB_CDEF, 1'b0, 64'd0);

    foreach (directed[i]) begin
      if (directed[i].is_write) begin
        write_reg(directed[i].reg_idx, directed[i].data);
      end else begin
        send_block(directed[i].data, directed[i].typed, directed[i].result);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // Each phase writes a random subset of the key halves and always the
      // direction; the first always writes all three.
      if (ph == 0 || $urandom_range(1)) write_reg(REG_KEY_HIGH, random_word());
      if (ph == 0 || $urandom_range(1)) write_reg(REG_KEY_LOW, random_word());
      write_reg(REG_DECRYPT, 64'($urandom_range(1)) | (64'($urandom()) << 1));
      if ($urandom_range(3) == 0) write_reg(REG_NONE, random_word());

      // Phase 2 holds the result side off so the core backs up its input;
      // phase 4 runs with no idling on either side at all.
      idling_enabled = (ph != 4);
      if (ph == 2) hold_off_go = 1'b1;

      for (int n = 0; n < PER_PHASE; n++) begin
        // Part-way through phase 6 the sender pauses until all are back.
        if (ph == 6 && n == PER_PHASE / 2) drain_results();
        send_block(random_word() ^ {$urandom(), $urandom()}, 1'b0, 64'd0);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    idling_enabled = 1'b1;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (pending_blocks.size() != 0) begin
      $error("block_out: %0d expected blocks never arrived", pending_blocks.size());
      fail_count++;
    end
    $display("Ran %0d blocks through %0d register writes, encrypting and decrypting,",
             requests_sent, key_writes);
    $display("with %0d results checked under random and held-off back-pressure.",
             blocks_checked);
    if (fail_count == 0) begin
      $display("** idea_block_cipher: PASSED **");
    end else begin
      $display("** idea_block_cipher: FAILED **");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off counted here.
  // ---------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_go) begin
        hold_off_go = 1'b0;
        out_stall = 1'b1;
        repeat (400) @(negedge clk);
      end
      out_stall = idling_enabled && ($urandom_range(99) < 21);
    end
  end

  // Every result taken is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_blocks.size() == 0) begin
        $error("block_out: result %h arrived with nothing expected", out_block_out);
        fail_count++;
      end else begin
        logic [63:0] want;
        want = pending_blocks.pop_front();
        blocks_checked++;
        if (out_block_out !== want) begin
          $error("block_out: expected %h, actual %h", want, out_block_out);
          fail_count++;
        end
      end
    end
  end

  // Backstop against a hang, far beyond the slowest legitimate run.
  initial begin
    #20_000_000;
    $display("** idea_block_cipher: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire
